>>> src/aps_pkg.sv
// aps_pkg: widths, register indexes, control word layout and the microcode
// table of the steering controller; no dependencies
`default_nettype none

package aps_pkg;

	localparam int POS_W   = 10;
	localparam int RATE_W  = 16;
	localparam int SPEED_W = 15;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;
	localparam int STEP_W  = 4;

	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 27;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 48;

	typedef enum logic [CIDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_FILTER_W   = 3'd3,
		REG_DEAD_BAND  = 3'd4,
		REG_SEP_THR    = 3'd5,
		REG_WINDUP_LIM = 3'd6,
		REG_STEER_LIM  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {A_W, A_WINV, A_KP, A_KI, A_KD} a_sel_t;
	typedef enum logic [2:0] {B_E, B_S, B_F, B_I, B_D} b_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic [2:0] {
		D_NONE, D_SMOOTH, D_DEADZONE, D_PID, D_STEER, D_OUT, D_HALT
	} dest_t;

	typedef struct packed {
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		acc_op_t           acc;
		dest_t             dest;
		logic              jump_halt;
		logic [STEP_W-1:0] target;
		logic              last;
	} cw_t;

	localparam logic [STEP_W-1:0] STEP_HALT = 4'd10;

	function automatic cw_t microcode(input logic [STEP_W-1:0] step);
		cw_t c;
		c = '{a_sel: A_W, b_sel: B_E, acc: ACC_HOLD, dest: D_NONE,
			jump_halt: 1'b0, target: '0, last: 1'b0};
		case (step)
			4'd0: begin
				// halted items skip straight to the stop result
				c.acc       = ACC_LOAD;
				c.jump_halt = 1'b1;
				c.target    = STEP_HALT;
			end
			4'd1: begin
				c.a_sel = A_WINV;
				c.b_sel = B_S;
				c.acc   = ACC_ADD;
			end
			4'd2: c.dest = D_SMOOTH;
			4'd3: c.dest = D_DEADZONE;
			4'd4: c.dest = D_PID;
			4'd5: begin
				c.a_sel = A_KP;
				c.b_sel = B_F;
				c.acc   = ACC_LOAD;
			end
			4'd6: begin
				c.a_sel = A_KI;
				c.b_sel = B_I;
				c.acc   = ACC_ADD;
			end
			4'd7: begin
				c.a_sel = A_KD;
				c.b_sel = B_D;
				c.acc   = ACC_ADD;
			end
			4'd8: c.dest = D_STEER;
			4'd9: begin
				c.dest = D_OUT;
				c.last = 1'b1;
			end
			4'd10: begin
				c.dest = D_HALT;
				c.last = 1'b1;
			end
			default: c.last = 1'b1;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/aps_if.sv
// aps_if: valid/ready channels of the steering controller (line item in,
// command item out, register writes); uses aps_pkg for widths
`default_nettype none

interface aps_in_if import aps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] line_position;
	logic             line_seen;
	logic             stop_request;

	modport source (output valid, line_position, line_seen, stop_request, input ready);
	modport sink (input valid, line_position, line_seen, stop_request, output ready);
endinterface

interface aps_out_if import aps_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] angular_rate;
	logic [SPEED_W-1:0]       forward_speed;
	logic                     halted;

	modport source (output valid, angular_rate, forward_speed, halted, input ready);
	modport sink (input valid, angular_rate, forward_speed, halted, output ready);
endinterface

interface aps_cfg_if import aps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/adaptive_pid_steering.sv
// adaptive_pid_steering: pid steering controller with low-pass filter,
// deadzone, gain adaptation and anti-windup; uses aps_pkg and aps_if
//
//  channel | direction | payload
//  cfg     | in        | index[2:0], data[31:0]
//  track   | in        | line_position[9:0], line_seen, stop_request
//  cmd     | out       | angular_rate[15:0] signed, forward_speed[14:0], halted
//
// an item is walked through the microcode steps on one shared 18x27
// multiply-accumulate unit; a new item is taken only after the last step
// has completed and busy has dropped. a halted item skips to the stop result.
// reset restores register defaults and clears filter, integral and latch.
// a full output register stalls the last step; cfg is always ready.
`default_nettype none

module adaptive_pid_steering import aps_pkg::*; #(
	parameter int IMAGE_WIDTH   = 640,
	parameter int MAX_TURN_RATE = 512,
	parameter int CRUISE_SPEED  = 128
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aps_cfg_if.sink    cfg,
	aps_in_if.sink     track,
	aps_out_if.source  cmd
);

	localparam int HALF = IMAGE_WIDTH / 2;
	localparam logic signed [12:0] HALF_S = 13'(HALF);
	localparam logic signed [16:0] TURN_MAX = 17'(MAX_TURN_RATE);
	localparam logic [SPEED_W-1:0] SPEED = SPEED_W'(CRUISE_SPEED);
	localparam logic signed [ACC_W-1:0] S_MAX = 48'sd524287;
	localparam logic signed [ACC_W-1:0] S_MIN = -48'sd524288;
	localparam logic signed [20:0] PREV_MAX = 21'sd1023;
	localparam logic signed [20:0] PREV_MIN = -21'sd1024;

	// configuration registers
	logic [15:0] gain_p_q, gain_i_q, gain_d_q, dead_band_q, sep_thr_q;
	logic [16:0] filter_w_q;
	logic [23:0] windup_lim_q;
	logic [31:0] steer_lim_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= 16'd256;
			gain_i_q     <= 16'd0;
			gain_d_q     <= 16'd0;
			filter_w_q   <= 17'd65536;
			dead_band_q  <= 16'd0;
			sep_thr_q    <= 16'd2560;
			windup_lim_q <= 24'd65535;
			steer_lim_q  <= 32'h8000_8000;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GAIN_P:     gain_p_q     <= cfg.data[15:0];
				REG_GAIN_I:     gain_i_q     <= cfg.data[15:0];
				REG_GAIN_D:     gain_d_q     <= cfg.data[15:0];
				REG_FILTER_W:   filter_w_q   <= cfg.data[16:0];
				REG_DEAD_BAND:  dead_band_q  <= cfg.data[15:0];
				REG_SEP_THR:    sep_thr_q    <= cfg.data[15:0];
				REG_WINDUP_LIM: windup_lim_q <= cfg.data[23:0];
				REG_STEER_LIM:  steer_lim_q  <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	// sequencer and output registers
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  pos_q;
	logic              seen_q, stop_q, latch_q;
	logic              out_valid_q, halted_q;
	logic signed [RATE_W-1:0] rate_q;
	logic [SPEED_W-1:0] speed_q;
	cw_t               cw;
	logic              out_free;
	logic signed [RATE_W-1:0] rate_new;

	assign cw       = microcode(step_q);
	assign out_free = !out_valid_q || cmd.ready;

	assign track.ready       = !busy_q;
	assign cmd.valid         = out_valid_q;
	assign cmd.angular_rate  = rate_q;
	assign cmd.forward_speed = speed_q;
	assign cmd.halted        = halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			pos_q       <= '0;
			seen_q      <= 1'b0;
			stop_q      <= 1'b0;
			latch_q     <= 1'b0;
			out_valid_q <= 1'b0;
			rate_q      <= '0;
			speed_q     <= '0;
			halted_q    <= 1'b0;
		end else begin
			if (busy_q && cw.last && out_free)
				out_valid_q <= 1'b1;
			else if (cmd.ready)
				out_valid_q <= 1'b0;
			if (!busy_q) begin
				if (track.valid) begin
					pos_q  <= track.line_position;
					seen_q <= track.line_seen;
					stop_q <= track.stop_request;
					busy_q <= 1'b1;
					step_q <= '0;
				end
			end else if (cw.last) begin
				if (out_free) begin
					busy_q <= 1'b0;
					if (cw.dest == D_HALT) begin
						latch_q  <= 1'b1;
						rate_q   <= '0;
						speed_q  <= '0;
						halted_q <= 1'b1;
					end else begin
						rate_q   <= rate_new;
						speed_q  <= SPEED;
						halted_q <= 1'b0;
					end
				end
			end else if (cw.jump_halt && (stop_q || latch_q)) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// shared multiply-accumulate
	logic [16:0] w_eff, w_inv;
	logic signed [12:0] pos_diff;
	logic signed [20:0] e_w;
	logic signed [MUL_A_W-1:0] kp_q, ki_q, kd_q, mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [19:0] s_q, f_q;
	logic signed [25:0] i_q;
	logic signed [10:0] prev_q;
	logic signed [12:0] d_q;
	logic signed [RATE_W-1:0] steer_q;

	assign w_eff    = (filter_w_q > 17'd65536) ? 17'd65536 : filter_w_q;
	assign w_inv    = 17'd65536 - w_eff;
	assign pos_diff = $signed({3'b000, pos_q}) - HALF_S;
	assign e_w      = seen_q ? {pos_diff, 8'h00} : '0;

	always_comb begin
		case (cw.a_sel)
			A_W:     mul_a = $signed({1'b0, w_eff});
			A_WINV:  mul_a = $signed({1'b0, w_inv});
			A_KP:    mul_a = kp_q;
			A_KI:    mul_a = ki_q;
			A_KD:    mul_a = kd_q;
			default: mul_a = '0;
		endcase
		case (cw.b_sel)
			B_E:     mul_b = MUL_B_W'(e_w);
			B_S:     mul_b = MUL_B_W'(s_q);
			B_F:     mul_b = MUL_B_W'(f_q);
			B_I:     mul_b = MUL_B_W'(i_q);
			B_D:     mul_b = MUL_B_W'($signed({d_q, 8'h00}));
			default: mul_b = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// filter rounding and saturation
	logic signed [ACC_W-1:0] s_rnd, s_sh;
	logic signed [19:0] s_new;

	always_comb begin
		s_rnd = acc_q + 48'sd32768;
		s_sh  = s_rnd >>> 16;
		if (s_sh > S_MAX)
			s_new = 20'sh7FFFF;
		else if (s_sh < S_MIN)
			s_new = 20'sh80000;
		else
			s_new = s_sh[19:0];
	end

	// deadzone
	logic signed [20:0] s_x, db_x, f_x;
	logic [20:0] abs_s;
	logic signed [19:0] f_new;

	always_comb begin
		s_x   = 21'(s_q);
		db_x  = $signed({5'b00000, dead_band_q});
		abs_s = s_q[19] ? -s_x : s_x;
		if (abs_s < {5'b00000, dead_band_q})
			f_x = '0;
		else if (s_x > 21'sd0)
			f_x = s_x - db_x;
		else
			f_x = s_x + db_x;
		f_new = f_x[19:0];
	end

	// gain adaptation, integral, derivative and previous error
	logic signed [20:0] fe, d_diff, d_sh, d_tr, p_sh, p_tr;
	logic [20:0] abs_f;
	logic big_err, small_err, d_fix, p_fix;
	logic signed [MUL_A_W-1:0] gp_x, gi_x, gd_x, kp_new, ki_new, kd_new;
	logic signed [26:0] i_sum, i_raw, lim_x, i_cl;
	logic signed [10:0] prev_new;

	always_comb begin
		fe        = 21'(f_q);
		abs_f     = f_q[19] ? -fe : fe;
		big_err   = abs_f > {4'b0000, sep_thr_q, 1'b0};
		small_err = abs_f < {5'b00000, sep_thr_q};

		gp_x   = MUL_A_W'($signed(gain_p_q));
		gi_x   = MUL_A_W'($signed(gain_i_q));
		gd_x   = MUL_A_W'($signed(gain_d_q));
		kp_new = big_err ? gp_x + (gp_x <<< 1) : gp_x <<< 1;
		ki_new = big_err ? gi_x : gi_x <<< 1;
		kd_new = big_err ? gd_x <<< 2 : gd_x <<< 1;

		i_sum = 27'(i_q) + 27'(f_q);
		i_raw = small_err ? i_sum : '0;
		lim_x = $signed({3'b000, windup_lim_q});
		if (i_raw > lim_x)
			i_cl = lim_x;
		else if (i_raw < -lim_x)
			i_cl = -lim_x;
		else
			i_cl = i_raw;

		// truncating division by 256 rounds negatives toward zero
		d_diff = fe - 21'($signed({prev_q, 8'h00}));
		d_sh   = d_diff >>> 8;
		d_fix  = d_diff[20] && (d_diff[7:0] != 8'h00);
		d_tr   = d_sh + 21'(d_fix);

		p_sh  = fe >>> 8;
		p_fix = fe[20] && (fe[7:0] != 8'h00);
		p_tr  = p_sh + 21'(p_fix);
		if (p_tr > PREV_MAX)
			prev_new = 11'sd1023;
		else if (p_tr < PREV_MIN)
			prev_new = -11'sd1024;
		else
			prev_new = p_tr[10:0];
	end

	// soft limits, then negate and turn-rate clamp
	logic signed [ACC_W-1:0] st_rnd, st_sh, hi_x, lo_x, st_hi, st_lo;
	logic signed [RATE_W-1:0] steer_new;
	logic signed [16:0] neg_x, rate_x;

	always_comb begin
		st_rnd    = acc_q + 48'sd256;
		st_sh     = st_rnd >>> 9;
		hi_x      = ACC_W'($signed(steer_lim_q[31:16]));
		lo_x      = ACC_W'($signed(steer_lim_q[15:0]));
		st_hi     = (st_sh > hi_x) ? hi_x : st_sh;
		st_lo     = (st_hi < lo_x) ? lo_x : st_hi;
		steer_new = st_lo[RATE_W-1:0];

		neg_x = -17'(steer_q);
		if (neg_x > TURN_MAX)
			rate_x = TURN_MAX;
		else if (neg_x < -TURN_MAX)
			rate_x = -TURN_MAX;
		else
			rate_x = neg_x;
		rate_new = rate_x[RATE_W-1:0];
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= '0;
			i_q    <= '0;
			prev_q <= '0;
		end else if (busy_q) begin
			if (cw.dest == D_SMOOTH)
				s_q <= s_new;
			if (cw.dest == D_PID) begin
				i_q    <= i_cl[25:0];
				prev_q <= prev_new;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (cw.acc)
				ACC_LOAD: acc_q <= ACC_W'(prod);
				ACC_ADD:  acc_q <= acc_q + ACC_W'(prod);
				default:  ;
			endcase
			if (cw.dest == D_DEADZONE)
				f_q <= f_new;
			if (cw.dest == D_PID) begin
				kp_q <= kp_new;
				ki_q <= ki_new;
				kd_q <= kd_new;
				d_q  <= d_tr[12:0];
			end
			if (cw.dest == D_STEER)
				steer_q <= steer_new;
		end
	end

endmodule

`default_nettype wire
